>>> design/pip_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Widths, operation and result codes, and the control word of the shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int COORD_W = 32;   // Q16.16 coordinate
  localparam int DIFF_W  = 33;   // difference of two coordinates
  localparam int OPND_W  = 34;   // signed multiplier operand
  localparam int PROD_W  = 68;   // signed multiplier product
  localparam int ACC_W   = 101;  // accumulator, holds a 100-bit square
  localparam int OP_W    = 2;
  localparam int LOC_W   = 2;
  localparam int TOL_W   = 16;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [LOC_W-1:0] LOC_OUTSIDE = 2'd0;
  localparam logic [LOC_W-1:0] LOC_INSIDE  = 2'd1;
  localparam logic [LOC_W-1:0] LOC_EDGE    = 2'd2;

  // Accumulator operations on the product register.
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // Left shift applied to the product before it is accumulated.
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_26 = 2'd1;
  localparam logic [1:0] SH_33 = 2'd2;
  localparam logic [1:0] SH_50 = 2'd3;

  typedef struct packed {
    logic signed [OPND_W-1:0] opa;
    logic signed [OPND_W-1:0] opb;
    logic [1:0]               acc_op;
    logic [1:0]               shift;
  } mac_ctrl_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

endpackage

>>> design/pip_if.sv
// ----------------------------------------------------------------------------
// Point-in-polygon channels
// Command channel (operation and point) and result channel (location).
// ----------------------------------------------------------------------------
interface pip_in_if import pip_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;

  modport source (output valid, output operation, output x, output y, input ready);
  modport sink   (input valid, input operation, input x, input y, output ready);
endinterface

interface pip_out_if import pip_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LOC_W-1:0] location;

  modport source (output valid, output location, input ready);
  modport sink   (input valid, input location, output ready);
endinterface

>>> design/pip_vertex_mem.sv
// ----------------------------------------------------------------------------
// Vertex memory
// One write port and one registered read port holding the polygon vertices.
// ----------------------------------------------------------------------------
module pip_vertex_mem import pip_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  vertex_t           wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output vertex_t           rdata
);

  vertex_t mem [DEPTH];

  // Write on append, registered read while the walk fetches.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/pip_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// A registered 34x34 signed multiplier followed by a shifting accumulator.
// ----------------------------------------------------------------------------
module pip_mac import pip_pkg::*; (
  input  logic                     clk,
  input  mac_ctrl_t                ctrl,
  output logic signed [PROD_W-1:0] prod,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [ACC_W-1:0] ext;
  logic signed [ACC_W-1:0] term;

  // The product of the previous cycle is sign extended and shifted.
  assign ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_comb begin
    unique case (ctrl.shift)
      SH_0:    term = ext;
      SH_26:   term = ext <<< 26;
      SH_33:   term = ext <<< 33;
      default: term = ext <<< 50;
    endcase
  end

  // Multiply in one cycle, accumulate the result in the next.
  always_ff @(posedge clk) begin
    prod <= ctrl.opa * ctrl.opb;
    unique case (ctrl.acc_op)
      ACC_LOAD: acc <= term;
      ACC_ADD:  acc <= acc + term;
      ACC_SUB:  acc <= acc - term;
      default:  acc <= acc;
    endcase
  end

endmodule

>>> design/point_in_polygon_test_top.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test by ray casting
// Stores a polygon and classifies query points as outside, inside or on edge.
// ----------------------------------------------------------------------------
// Clear and append words are taken without a stall and give no result. A
// test word walks the edges of the stored polygon and delivers one result;
// an empty polygon skips the walk, and the walk stops early when the
// point lies on an edge. The command channel is not ready meanwhile. The
// walk is paced by the single shared 34x34 multiplier, which forms eleven
// products per edge (cross, dot and squared length, then the exact
// on-edge compare) under a step counter, plus one vertex fetch per edge.
module point_in_polygon_test_top import pip_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic             clk,
  input  logic             rst,
  pip_in_if.sink           cmd,
  pip_out_if.source        res,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd12;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCHA = 3'd1;
  localparam logic [2:0] S_FETCHB = 3'd2;
  localparam logic [2:0] S_DIFF   = 3'd3;
  localparam logic [2:0] S_EDGE   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]                state;
  logic [TOL_W-1:0]          tol;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          idx;
  logic [STEP_W-1:0]         step;
  logic signed [COORD_W-1:0] px, py, ax, ay;
  logic signed [DIFF_W-1:0]  dx, dy, wx, wy;
  logic [2*TOL_W-1:0]        tol2;
  logic signed [65:0]        cross_val;
  logic signed [65:0]        cross_neg_v;
  logic [64:0]               acr;
  logic signed [65:0]        dot;
  logic [64:0]               len2;
  logic [99:0]               lhs;
  logic                      parity;
  logic                      out_valid;
  logic [LOC_W-1:0]          out_loc;
  logic [LOC_W-1:0]          fin_loc;

  logic                      accept;
  logic                      mem_we, mem_re;
  logic [ADDR_W-1:0]         mem_raddr;
  vertex_t                   wr_vertex, rd_vertex;
  mac_ctrl_t                 ctrl;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic                      near, on_edge, hit, parity_next;
  logic                      dy_pos, dy_neg, cross_zero;
  logic [CNT_W-1:0]          last_idx;

  assign cmd.ready    = (state == S_IDLE);
  assign accept       = cmd.valid && cmd.ready;
  assign res.valid    = out_valid;
  assign res.location = out_loc;
  assign last_idx     = count - CNT_W'(1);

  // Vertex storage.
  assign mem_we      = accept && (cmd.operation == OP_APPEND) &&
                       (count < CNT_W'(MAX_VERTICES));
  assign wr_vertex.x = cmd.x;
  assign wr_vertex.y = cmd.y;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (state == S_FETCHA) begin
      mem_re    = 1'b1;
      mem_raddr = last_idx[ADDR_W-1:0];
    end else if (state == S_FETCHB) begin
      mem_re    = 1'b1;
      mem_raddr = '0;
    end else if (state == S_EDGE && step == '0) begin
      mem_re    = 1'b1;
      mem_raddr = idx[ADDR_W-1:0] + ADDR_W'(1);
    end
  end

  pip_vertex_mem #(
    .DEPTH (MAX_VERTICES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (wr_vertex),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_vertex)
  );

  // Micro program of the shared multiplier, one product issued per step up to step 10.
  always_comb begin
    ctrl.opa    = '0;
    ctrl.opb    = '0;
    ctrl.acc_op = ACC_HOLD;
    ctrl.shift  = SH_0;
    if (state == S_FETCHA) begin
      ctrl.opa = OPND_W'(tol);
      ctrl.opb = OPND_W'(tol);
    end else if (state == S_EDGE) begin
      unique case (step)
        4'd0: begin
          ctrl.opa = OPND_W'(dx);
          ctrl.opb = OPND_W'(wy);
        end
        4'd1: begin
          ctrl.opa    = OPND_W'(dy);
          ctrl.opb    = OPND_W'(wx);
          ctrl.acc_op = ACC_LOAD;
        end
        4'd2: begin
          ctrl.opa    = OPND_W'(dx);
          ctrl.opb    = OPND_W'(wx);
          ctrl.acc_op = ACC_SUB;
        end
        4'd3: begin
          ctrl.opa    = OPND_W'(dy);
          ctrl.opb    = OPND_W'(wy);
          ctrl.acc_op = ACC_LOAD;
        end
        4'd4: begin
          ctrl.opa    = OPND_W'(dx);
          ctrl.opb    = OPND_W'(dx);
          ctrl.acc_op = ACC_ADD;
        end
        4'd5: begin
          ctrl.opa    = OPND_W'(dy);
          ctrl.opb    = OPND_W'(dy);
          ctrl.acc_op = ACC_LOAD;
        end
        4'd6: begin
          ctrl.opa    = OPND_W'(acr[49:25]);
          ctrl.opb    = OPND_W'(acr[49:25]);
          ctrl.acc_op = ACC_ADD;
        end
        4'd7: begin
          ctrl.opa    = OPND_W'(acr[49:25]);
          ctrl.opb    = OPND_W'(acr[24:0]);
          ctrl.acc_op = ACC_LOAD;
          ctrl.shift  = SH_50;
        end
        4'd8: begin
          ctrl.opa    = OPND_W'(acr[24:0]);
          ctrl.opb    = OPND_W'(acr[24:0]);
          ctrl.acc_op = ACC_ADD;
          ctrl.shift  = SH_26;
        end
        4'd9: begin
          ctrl.opa    = OPND_W'(len2[64:33]);
          ctrl.opb    = OPND_W'(tol2);
          ctrl.acc_op = ACC_ADD;
        end
        4'd10: begin
          ctrl.opa    = OPND_W'(len2[32:0]);
          ctrl.opb    = OPND_W'(tol2);
          ctrl.acc_op = ACC_LOAD;
          ctrl.shift  = SH_33;
        end
        4'd11: begin
          ctrl.acc_op = ACC_ADD;
        end
        default: begin
          ctrl.acc_op = ACC_HOLD;
        end
      endcase
    end
  end

  pip_mac u_mac (
    .clk  (clk),
    .ctrl (ctrl),
    .prod (prod),
    .acc  (acc)
  );

  // Edge classification once the tolerance product sits in the accumulator.
  assign cross_neg_v = -cross_val;
  assign cross_zero  = (cross_val == '0);
  assign near        = (acr[64:50] == '0) && ({1'b0, lhs} < $unsigned(acc));
  assign on_edge     = near && !dot[65] && (dot < $signed({1'b0, len2}));
  assign dy_pos      = !dy[DIFF_W-1] && (dy != '0);
  assign dy_neg      = dy[DIFF_W-1];

  always_comb begin
    hit = 1'b0;
    if (dy_pos) begin
      hit = !wy[DIFF_W-1] && (wy < dy) && (cross_val[65] || cross_zero);
    end else if (dy_neg) begin
      hit = (wy[DIFF_W-1] || (wy == '0)) && (wy > dy) && !cross_val[65];
    end
  end

  assign parity_next = parity ^ hit;

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tol       <= TOL_W'(7);
      count     <= '0;
      idx       <= '0;
      step      <= '0;
      parity    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol <= cfg_data;
      end

      if (state == S_FINISH && (!out_valid || res.ready)) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.operation == OP_CLEAR) begin
              count <= '0;
            end else if (cmd.operation == OP_APPEND) begin
              if (count < CNT_W'(MAX_VERTICES)) begin
                count <= count + CNT_W'(1);
              end
            end else if (cmd.operation == OP_TEST) begin
              idx    <= '0;
              parity <= 1'b0;
              if (count == '0) begin
                state <= S_FINISH;
              end else begin
                state <= S_FETCHA;
              end
            end
          end
        end
        S_FETCHA: state <= S_FETCHB;
        S_FETCHB: state <= S_DIFF;
        S_DIFF: begin
          step  <= '0;
          state <= S_EDGE;
        end
        S_EDGE: begin
          if (step != STEP_LAST) begin
            step <= step + STEP_W'(1);
          end else if (on_edge) begin
            state <= S_FINISH;
          end else begin
            parity <= parity_next;
            if (idx == last_idx) begin
              state <= S_FINISH;
            end else begin
              idx   <= idx + CNT_W'(1);
              state <= S_DIFF;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid || res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the edge walk.
  always_ff @(posedge clk) begin
    if (accept && cmd.operation == OP_TEST) begin
      px      <= cmd.x;
      py      <= cmd.y;
      fin_loc <= LOC_OUTSIDE;
    end
    if (state == S_FETCHB) begin
      ax   <= rd_vertex.x;
      ay   <= rd_vertex.y;
      tol2 <= prod[2*TOL_W-1:0];
    end
    if (state == S_DIFF) begin
      dx <= DIFF_W'(rd_vertex.x) - DIFF_W'(ax);
      dy <= DIFF_W'(rd_vertex.y) - DIFF_W'(ay);
      wx <= DIFF_W'(px) - DIFF_W'(ax);
      wy <= DIFF_W'(py) - DIFF_W'(ay);
      ax <= rd_vertex.x;
      ay <= rd_vertex.y;
    end
    if (state == S_EDGE) begin
      unique case (step)
        4'd3:  cross_val <= acc[65:0];
        4'd4:  acr       <= cross_val[65] ? cross_neg_v[64:0] : cross_val[64:0];
        4'd5:  dot       <= acc[65:0];
        4'd7:  len2      <= acc[64:0];
        4'd10: lhs       <= acc[99:0];
        4'd12: begin
          if (on_edge) begin
            fin_loc <= LOC_EDGE;
          end else if (idx == last_idx) begin
            fin_loc <= parity_next ? LOC_INSIDE : LOC_OUTSIDE;
          end
        end
        default: begin
        end
      endcase
    end
    if (state == S_FINISH && (!out_valid || res.ready)) begin
      out_loc <= fin_loc;
    end
  end

endmodule

>>> design/pip_checker.sv
// ----------------------------------------------------------------------------
// Point-in-polygon port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module pip_checker import pip_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic [OP_W-1:0]  cmd_operation,
  input logic             res_valid,
  input logic             res_ready,
  input logic [LOC_W-1:0] res_location
);

  // A stalled result word holds its value.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_location))
    else $error("result word changed while stalled");

  // A delivered location is always one of the three answers.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_location == LOC_OUTSIDE || res_location == LOC_INSIDE ||
                   res_location == LOC_EDGE))
    else $error("result location out of range");

  // A test word occupies the block: no word is taken in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_operation == OP_TEST |=> !cmd_ready)
    else $error("command taken right after a test");

  // Clear, append and unused words leave the block ready in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_operation != OP_TEST |=> cmd_ready)
    else $error("block stalled after a clear or append");

endmodule

bind point_in_polygon_test_top pip_checker u_pip_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .cmd_operation (cmd.operation),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_location  (res.location)
);

>>> dv/point_in_polygon_checker.sv
// ----------------------------------------------------------------------------
// Point-in-polygon checker
// Watches the command, result and tolerance ports, predicts each location
// from its own copy of the polygon, and compares results in order.
// ----------------------------------------------------------------------------
module point_in_polygon_checker import pip_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic             clk,
  input  logic             rst,
  pip_in_if                cmd,
  pip_out_if               res,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_data,
  output int               errors,
  output int               pending,
  output int               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the polygon and of the tolerance register.
  logic signed [COORD_W-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] poly_y [MAX_VERTICES];
  int                        n_vert;
  logic [TOL_W-1:0]          tolerance;
  logic [LOC_W-1:0]          location_q [$];

  // Walks the edges from the closing one onward, stopping at one that holds the point; exact wide arithmetic.
  function automatic logic [LOC_W-1:0] locate(input logic signed [COORD_W-1:0] px,
                                               input logic signed [COORD_W-1:0] py);
    logic signed [199:0] ax, ay, dx, dy, wx, wy, crs, dt, len2, acr, tol;
    logic                odd;
    int                  j;
    odd = 1'b0;
    tol = {184'd0, tolerance};
    for (int i = 0; i < n_vert; i++) begin
      j = (i == 0) ? n_vert - 1 : i - 1;
      ax = poly_x[j];
      ay = poly_y[j];
      dx = poly_x[i];
      dy = poly_y[i];
      dx = dx - ax;
      dy = dy - ay;
      wx = px;
      wy = py;
      wx = wx - ax;
      wy = wy - ay;
      crs = dx * wy - dy * wx;
      dt = dx * wx + dy * wy;
      len2 = dx * dx + dy * dy;
      acr = (crs < 0) ? -crs : crs;
      if (acr * acr < tol * tol * len2 && dt >= 0 && dt < len2) return LOC_EDGE;
      // Ray toward -x; horizontal edges never toggle.
      if (dy > 0) begin
        if (wy >= 0 && wy < dy && crs <= 0) odd = ~odd;
      end else if (dy < 0) begin
        if (wy <= 0 && wy > dy && crs >= 0) odd = ~odd;
      end
    end
    return odd ? LOC_INSIDE : LOC_OUTSIDE;
  endfunction

  // Update the shadow state on each accepted word and check each result.
  always @(posedge clk) begin
    logic [LOC_W-1:0] want;
    if (rst) begin
      n_vert = 0;
      tolerance = TOL_W'(7);
      location_q.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_we) tolerance = cfg_data;
      if (res.valid && res.ready) begin
        if (location_q.size() == 0) begin
          $display("%0t: unexpected location %0d", $time, res.location);
          errors++;
        end else begin
          want = location_q.pop_front();
          checked++;
          if (res.location !== want) begin
            $display("%0t: location mismatch, expected %0d, actual %0d",
                     $time, want, res.location);
            errors++;
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        case (cmd.operation)
          OP_CLEAR: n_vert = 0;
          OP_APPEND: begin
            if (n_vert < MAX_VERTICES) begin
              poly_x[n_vert] = cmd.x;
              poly_y[n_vert] = cmd.y;
              n_vert++;
            end
          end
          OP_TEST: location_q.push_back(locate(cmd.x, cmd.y));
          default: ;
        endcase
      end
    end
    pending = location_q.size();
  end

endmodule

>>> dv/tb_point_in_polygon_test_top.sv
// ----------------------------------------------------------------------------
// Point-in-polygon testbench
// Loads polygons of many shapes and sizes, queries points on, near, inside
// and outside them under several tolerances, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_test_top;
  import pip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_VERT   = 64;
  localparam int WORD_GOAL  = 1350;
  localparam int IDLE_LIMIT = 20000;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [TOL_W-1:0] cfg_data;
  int               errors, pending, checked;
  int               n_words, n_tests, n_cfg, burst, idle_cycles, ready_mode;
  logic signed [COORD_W-1:0] vx [$];
  logic signed [COORD_W-1:0] vy [$];

  pip_in_if  cmd_if ();
  pip_out_if res_if ();

  point_in_polygon_test_top #(.MAX_VERTICES(NUM_VERT)) DUT (
    .clk(clk), .rst(rst), .cmd(cmd_if), .res(res_if),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  point_in_polygon_checker #(.MAX_VERTICES(NUM_VERT)) u_checker (
    .clk(clk), .rst(rst), .cmd(cmd_if), .res(res_if),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .checked(checked)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // The result side stalls on a pattern that is chosen again at random times.
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= ($urandom_range(0, 1) == 0);
      2: res_if.ready <= ($urandom_range(0, 3) == 0);
      default: res_if.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [COORD_W-1:0] any_coord();
    return $signed($urandom);
  endfunction

  // Sends one word; the sender may pause between bursts of random length.
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [COORD_W-1:0] px,
                           input logic signed [COORD_W-1:0] py);
    int gap;
    if (burst == 0) begin
      burst = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst--;
    @(negedge clk);
    cmd_if.valid <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.x <= px;
    cmd_if.y <= py;
    do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
    if (op != OP_UNUSED) n_words++;
    if (op == OP_TEST) n_tests++;
  endtask

  // Tolerance changes only once every location has come back.
  task automatic set_tolerance(input logic [TOL_W-1:0] tol);
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= tol;
    @(negedge clk);
    cfg_we <= 1'b0;
    burst = 0;
    n_cfg++;
  endtask

  task automatic add_vertex(input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py);
    vx.push_back(px);
    vy.push_back(py);
    send_word(OP_APPEND, px, py);
  endtask

  task automatic clear_polygon();
    vx.delete();
    vy.delete();
    send_word(OP_CLEAR, any_coord(), any_coord());
  endtask

  // Picks a query point on a vertex, on or near an edge, nearby or anywhere.
  task automatic random_test(input logic signed [COORD_W-1:0] cx,
                             input logic signed [COORD_W-1:0] cy, input int sh);
    int i, j, kind;
    logic signed [COORD_W-1:0] px, py;
    kind = $urandom_range(0, 9);
    px = cx + ($signed($urandom) >>> (32 - sh));
    py = cy + ($signed($urandom) >>> (32 - sh));
    if (vx.size() > 0 && kind < 6) begin
      i = $urandom_range(0, vx.size() - 1);
      j = (i == 0) ? vx.size() - 1 : i - 1;
      if (kind == 0) begin
        px = vx[i];
        py = vy[i];
      end else begin
        px = COORD_W'((33'(signed'(vx[i])) + 33'(signed'(vx[j]))) >>> 1);
        py = COORD_W'((33'(signed'(vy[i])) + 33'(signed'(vy[j]))) >>> 1);
        if (kind > 2) begin
          px = px + $signed($urandom_range(0, 20)) - 10;
          py = py + $signed($urandom_range(0, 20)) - 10;
        end
      end
    end else if (kind == 9) begin
      px = any_coord();
      py = any_coord();
    end
    send_word(OP_TEST, px, py);
  endtask

  initial begin
    int n, k, sh, shape, c;
    logic signed [COORD_W-1:0] cx, cy, px, py;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    cmd_if.valid = 1'b0;
    cmd_if.operation = OP_CLEAR;
    cmd_if.x = '0;
    cmd_if.y = '0;
    n_words = 0;
    n_tests = 0;
    n_cfg = 0;
    burst = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty polygon, unused code, extreme corners, a square with a
    // zero-length edge, and points on and near an edge under three tolerances.
    send_word(OP_TEST, '0, '0);
    send_word(OP_UNUSED, 32'sh7fff_ffff, 32'sh8000_0000);
    clear_polygon();
    add_vertex(32'sh8000_0000, 32'sh8000_0000);
    add_vertex(32'sh7fff_ffff, 32'sh8000_0000);
    add_vertex(32'sh7fff_ffff, 32'sh7fff_ffff);
    add_vertex(32'sh8000_0000, 32'sh7fff_ffff);
    send_word(OP_TEST, '0, '0);
    send_word(OP_TEST, 32'sh8000_0000, '0);
    send_word(OP_TEST, 32'sh7fff_ffff, 32'sh7fff_ffff);
    clear_polygon();
    add_vertex(32'sh0, 32'sh0);
    add_vertex(32'sh000a_0000, 32'sh0);
    add_vertex(32'sh000a_0000, 32'sh000a_0000);
    add_vertex(32'sh0, 32'sh000a_0000);
    add_vertex(32'sh0, 32'sh000a_0000);
    send_word(OP_TEST, 32'sh0005_0000, 32'sh0005_0000);
    send_word(OP_TEST, 32'sh0005_0000, 32'sh0);
    send_word(OP_TEST, 32'sh0014_0000, 32'sh0005_0000);
    send_word(OP_TEST, 32'sh0005_0000, 32'sh3);
    set_tolerance('0);
    send_word(OP_TEST, 32'sh0005_0000, 32'sh0);
    set_tolerance(16'hffff);
    send_word(OP_TEST, 32'sh0005_0000, -32'sh3);
    set_tolerance(16'd7);

    // Random polygons and queries, mostly small shapes, a few over-full.
    while (n_words < WORD_GOAL) begin
      c = $urandom_range(0, 9);
      if (c < 3) begin
        case ($urandom_range(0, 4))
          0: set_tolerance('0);
          1: set_tolerance(16'hffff);
          2: set_tolerance(16'd7);
          3: set_tolerance(TOL_W'($urandom_range(0, 255)));
          default: set_tolerance(TOL_W'($urandom));
        endcase
      end
      c = $urandom_range(0, 99);
      n = (c < 70) ? $urandom_range(3, 8) : (c < 90) ? $urandom_range(9, 20) :
          (c < 97) ? $urandom_range(0, 2) : $urandom_range(60, 68);
      sh = $urandom_range(4, 28);
      cx = $signed($urandom) >>> $urandom_range(0, 8);
      cy = $signed($urandom) >>> $urandom_range(0, 8);
      shape = $urandom_range(0, 3);
      clear_polygon();
      px = cx;
      py = cy;
      for (int v = 0; v < n; v++) begin
        case (shape)
          0: begin
            px = cx + ($signed($urandom) >>> (32 - sh));
            py = cy + ($signed($urandom) >>> (32 - sh));
          end
          1: begin
            // Axis-aligned steps give edges parallel to the ray.
            if (v % 2) px = cx + ($signed($urandom) >>> (32 - sh));
            else py = cy + ($signed($urandom) >>> (32 - sh));
          end
          2: begin
            px = any_coord();
            py = any_coord();
          end
          default: begin
            if ($urandom_range(0, 2) != 0) begin
              px = cx + ($signed($urandom) >>> (32 - sh));
              py = cy + ($signed($urandom) >>> (32 - sh));
            end
          end
        endcase
        add_vertex(px, py);
      end
      if ($urandom_range(0, 19) == 0) send_word(OP_UNUSED, any_coord(), any_coord());
      k = $urandom_range(3, 10);
      repeat (k) random_test(cx, cy, sh);
    end

    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d words (%0d point tests) under %0d tolerance settings.",
             n_words, n_tests, n_cfg);
    $display("Checked %0d locations with %0d mismatches.", checked, errors);
    if (errors == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> point_in_polygon_test_top.f
design/pip_pkg.sv
design/pip_if.sv
design/pip_vertex_mem.sv
design/pip_mac.sv
design/point_in_polygon_test_top.sv
design/pip_checker.sv
dv/point_in_polygon_checker.sv
dv/tb_point_in_polygon_test_top.sv
